// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the heap RTL.
// Depends on the including module having aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define BMH_NEVER(lbl, expr, msg) \
    `BMH_ASSERT(lbl, !(expr), msg)

`endif

// ----- rtl/core/bmh_pkg.sv -----
// Package for the binary min-heap priority queue: sizes, codes, command and status types.
// No dependencies; imported by bmh_ctrl, bmh_dpath and the top level.
package bmh_pkg;

    localparam int HEAP_DEPTH = 16;
    localparam int KEY_W      = 32;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CHILD_W    = IDX_W + 2;
    localparam int REQ_W      = 2;
    localparam int STS_W      = 2;
    localparam int S_TDATA_W  = ((KEY_W + IDX_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * KEY_W + 1 + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [KEY_W-1:0] key_t;

    localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(HEAP_DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_EXTRACT  = 2'd1,
        REQ_DECREASE = 2'd2,
        REQ_DELETE   = 2'd3
    } req_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_BAD   = 2'd3
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_TAKE_RD,
        S_TAKE,
        S_DN_RD,
        S_DN_CMP,
        S_FIN,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_LOOK,
        RD_PARENT,
        RD_KIDS,
        RD_LAST,
        RD_ROOT
    } rd_mode_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_KEY,
        CUR_RDB
    } cur_op_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_COUNT,
        POS_IDX,
        POS_ZERO,
        POS_PARENT,
        POS_LEFT,
        POS_RIGHT
    } pos_op_t;

    typedef enum logic [1:0] {
        WR_CUR,
        WR_RDA,
        WR_RDB
    } wr_src_t;

    typedef struct packed {
        logic     load_req;
        rd_mode_t rd_mode;
        cnt_op_t  cnt_op;
        cur_op_t  cur_op;
        pos_op_t  pos_op;
        logic     wr_en;
        wr_src_t  wr_src;
        logic     set_status;
        logic     set_extr;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic chk_fail;
        logic pos_zero;
        logic up_less;
        logic dn_left;
        logic dn_right;
        logic last_one;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/core/binary_min_heap_priority_queue_unit.sv -----
// Binary min-heap priority queue of signed keys, top level.
// Channels: s_ beats carry a request, m_ beats carry one result per request.
// s_tuser = request type; s_tdata = key value, then entry index (low bit first).
// m_tuser = status; m_tdata = extracted value, min value, min valid, entry count.
// cfg_wen/cfg_wdata write the capacity limit; write only while the block is idle.
// One request at a time: a request walks the heap level by level in the sift loop,
// with one registered memory read per level; a delete climbs to the root and
// then sifts back down.
// A finished result sits in an output register; the next request is accepted
// while it waits, but its own result is held back until the receiver takes the
// earlier beat.
// Reset empties the heap (entry count zero), sets the capacity to the full depth
// and drops any pending result beat; heap contents need no clearing.
module binary_min_heap_priority_queue_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [bmh_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_value, entry_index
    input  logic [bmh_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [bmh_pkg::REQ_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // extracted_value, min_value, min_valid, entry_count
    output logic [bmh_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [bmh_pkg::STS_W-1:0]      m_tuser
);
    import bmh_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bmh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmh_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- rtl/core/bmh_ctrl.sv -----
// Controller state machine for the min-heap queue: sequences lookup, sift up,
// sift down and result load. Depends on bmh_pkg; drives bmh_dpath via cmd_t.
module bmh_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bmh_pkg::stat_t stat,
    output bmh_pkg::cmd_t  cmd
);
    import bmh_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   forced;

    assign forced   = (stat.req == REQ_DELETE);
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.load_req   = 1'b0;
        cmd.rd_mode    = RD_NONE;
        cmd.cnt_op     = CNT_HOLD;
        cmd.cur_op     = CUR_HOLD;
        cmd.pos_op     = POS_HOLD;
        cmd.wr_en      = 1'b0;
        cmd.wr_src     = WR_CUR;
        cmd.set_status = 1'b0;
        cmd.set_extr   = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.rd_mode = RD_LOOK;
                state_next  = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.set_status = 1'b1;
                if (stat.chk_fail) begin
                    state_next = S_FIN;
                end else begin
                    unique case (stat.req)
                        REQ_INSERT: begin
                            cmd.pos_op = POS_COUNT;
                            cmd.cnt_op = CNT_INC;
                            cmd.cur_op = CUR_KEY;
                            state_next = S_UP_RD;
                        end
                        REQ_EXTRACT: begin
                            cmd.set_extr = 1'b1;
                            cmd.cnt_op   = CNT_DEC;
                            cmd.cur_op   = CUR_RDB;
                            cmd.pos_op   = POS_ZERO;
                            state_next   = stat.last_one ? S_FIN : S_DN_RD;
                        end
                        REQ_DECREASE: begin
                            cmd.pos_op = POS_IDX;
                            cmd.cur_op = CUR_KEY;
                            state_next = S_UP_RD;
                        end
                        default: begin
                            cmd.pos_op = POS_IDX;
                            state_next = S_UP_RD;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (stat.pos_zero) begin
                    if (forced) begin
                        state_next = S_TAKE_RD;
                    end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = WR_CUR;
                        state_next = S_FIN;
                    end
                end else begin
                    cmd.rd_mode = RD_PARENT;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmd.wr_en = 1'b1;
                if (forced || stat.up_less) begin
                    cmd.wr_src = WR_RDA;
                    cmd.pos_op = POS_PARENT;
                    state_next = S_UP_RD;
                end else begin
                    cmd.wr_src = WR_CUR;
                    state_next = S_FIN;
                end
            end
            S_TAKE_RD: begin
                cmd.rd_mode = RD_LAST;
                state_next  = S_TAKE;
            end
            S_TAKE: begin
                cmd.cnt_op = CNT_DEC;
                cmd.cur_op = CUR_RDB;
                cmd.pos_op = POS_ZERO;
                state_next = stat.last_one ? S_FIN : S_DN_RD;
            end
            S_DN_RD: begin
                cmd.rd_mode = RD_KIDS;
                state_next  = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmd.wr_en = 1'b1;
                if (stat.dn_right) begin
                    cmd.wr_src = WR_RDB;
                    cmd.pos_op = POS_RIGHT;
                    state_next = S_DN_RD;
                end else if (stat.dn_left) begin
                    cmd.wr_src = WR_RDA;
                    cmd.pos_op = POS_LEFT;
                    state_next = S_DN_RD;
                end else begin
                    cmd.wr_src = WR_CUR;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.rd_mode = RD_ROOT;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/bmh_dpath.sv -----
// Datapath for the min-heap queue: heap memory, count, capacity, sift registers
// and the result beat register. Depends on bmh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bmh_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [bmh_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic [bmh_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [bmh_pkg::REQ_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bmh_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [bmh_pkg::STS_W-1:0]      m_tuser,
    input  bmh_pkg::cmd_t                  cmd,
    output bmh_pkg::stat_t                 stat
);
    import bmh_pkg::*;

    key_t heap_mem [HEAP_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic             out_valid_reg, out_valid_next;

    req_t             req_reg;
    key_t             key_reg;
    logic [IDX_W-1:0] idx_reg;
    key_t             cur_reg, cur_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    sts_t             status_reg, status_next;
    key_t             extr_reg, extr_next;
    key_t             rd_a_reg;
    key_t             rd_b_reg;

    sts_t             out_status_reg;
    key_t             out_extr_reg;
    key_t             out_min_reg;
    logic             out_minv_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic [CNT_W-1:0]   eff_cap;
    logic [CNT_W-1:0]   last_pos;
    logic [IDX_W-1:0]   pos_m1;
    logic [IDX_W-1:0]   parent_pos;
    logic [CHILD_W-1:0] left_pos;
    logic [CHILD_W-1:0] right_pos;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               rd_en;
    key_t               wr_data;
    key_t               best_val;
    sts_t               chk_code;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_reg > CNT_W'(HEAP_DEPTH)) begin
            eff_cap = CNT_W'(HEAP_DEPTH);
        end else begin
            eff_cap = cap_reg;
        end
    end

    assign last_pos   = count_reg - CNT_W'(1);
    assign pos_m1     = pos_reg - IDX_W'(1);
    assign parent_pos = {1'b0, pos_m1[IDX_W-1:1]};
    assign left_pos   = {1'b0, pos_reg, 1'b1};
    assign right_pos  = left_pos + CHILD_W'(1);

    always_comb begin
        rd_en     = 1'b1;
        rd_addr_a = '0;
        rd_addr_b = last_pos[IDX_W-1:0];
        unique case (cmd.rd_mode)
            RD_NONE:   rd_en = 1'b0;
            RD_LOOK:   rd_addr_a = (req_reg == REQ_EXTRACT) ? '0 : idx_reg;
            RD_PARENT: rd_addr_a = parent_pos;
            RD_KIDS: begin
                rd_addr_a = left_pos[IDX_W-1:0];
                rd_addr_b = right_pos[IDX_W-1:0];
            end
            RD_LAST:   rd_addr_b = last_pos[IDX_W-1:0];
            RD_ROOT:   rd_addr_a = '0;
            default:   rd_en = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cmd.wr_src)
            WR_RDA:  wr_data = rd_a_reg;
            WR_RDB:  wr_data = rd_b_reg;
            default: wr_data = cur_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            heap_mem[pos_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= heap_mem[rd_addr_a];
            rd_b_reg <= heap_mem[rd_addr_b];
        end
    end

    always_comb begin
        chk_code = STS_OK;
        unique case (req_reg)
            REQ_INSERT: begin
                if (count_reg >= eff_cap) chk_code = STS_FULL;
            end
            REQ_EXTRACT: begin
                if (count_reg == '0) chk_code = STS_EMPTY;
            end
            REQ_DECREASE: begin
                if (CNT_W'(idx_reg) >= count_reg || rd_a_reg < key_reg) chk_code = STS_BAD;
            end
            default: begin
                if (CNT_W'(idx_reg) >= count_reg) chk_code = STS_BAD;
            end
        endcase
    end

    assign best_val = stat.dn_left ? rd_a_reg : cur_reg;

    assign stat.req      = req_reg;
    assign stat.chk_fail = (chk_code != STS_OK);
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.up_less  = (cur_reg < rd_a_reg);
    assign stat.dn_left  = (left_pos < CHILD_W'(count_reg)) && (rd_a_reg < cur_reg);
    assign stat.dn_right = (right_pos < CHILD_W'(count_reg)) && (rd_b_reg < best_val);
    assign stat.last_one = (count_reg == CNT_W'(1));
    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb begin
        count_next = count_reg;
        unique case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
        cap_next       = cfg_wen ? cfg_wdata : cap_reg;
        out_valid_next = cmd.load_out | (out_valid_reg & ~m_tready);
    end

    always_comb begin
        unique case (cmd.cur_op)
            CUR_KEY: cur_next = key_reg;
            CUR_RDB: cur_next = rd_b_reg;
            default: cur_next = cur_reg;
        endcase
        unique case (cmd.pos_op)
            POS_COUNT:  pos_next = count_reg[IDX_W-1:0];
            POS_IDX:    pos_next = idx_reg;
            POS_ZERO:   pos_next = '0;
            POS_PARENT: pos_next = parent_pos;
            POS_LEFT:   pos_next = left_pos[IDX_W-1:0];
            POS_RIGHT:  pos_next = right_pos[IDX_W-1:0];
            default:    pos_next = pos_reg;
        endcase
        status_next = status_reg;
        extr_next   = extr_reg;
        if (cmd.load_req) begin
            status_next = STS_OK;
            extr_next   = KEY_MAX;
        end
        if (cmd.set_status) begin
            status_next = chk_code;
        end
        if (cmd.set_extr) begin
            extr_next = rd_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req_t'(s_tuser);
            key_reg <= s_tdata[KEY_W-1:0];
            idx_reg <= s_tdata[KEY_W +: IDX_W];
        end
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        extr_reg   <= extr_next;
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_extr_reg   <= extr_reg;
            out_min_reg    <= (count_reg != '0) ? rd_a_reg : '0;
            out_minv_reg   <= (count_reg != '0);
            out_cnt_reg    <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[KEY_W-1:0]         = out_extr_reg;
        m_tdata[KEY_W +: KEY_W]    = out_min_reg;
        m_tdata[2*KEY_W]           = out_minv_reg;
        m_tdata[2*KEY_W+1 +: CNT_W] = out_cnt_reg;
    end

    `BMH_NEVER(a_cnt_over, count_reg > CNT_W'(HEAP_DEPTH), "entry count above heap depth")
    `BMH_ASSERT(a_wr_live, cmd.wr_en |-> (CNT_W'(pos_reg) < count_reg), "write outside live entries")
    `BMH_ASSERT(a_inc_room, (cmd.cnt_op == CNT_INC) |-> (count_reg < eff_cap), "insert past capacity")
    `BMH_ASSERT(a_dec_live, (cmd.cnt_op == CNT_DEC) |-> (count_reg != '0), "remove from empty heap")

endmodule
